// ----- rtl/rsib_pkg.sv -----
// Package for the rank/select index builder: shared constants, result word codes
// and the queue entry type. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rsib_pkg;

    // Default geometry of the index.
    localparam int UNIT_BITS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 40;

    // Fixed widths of the result words and the shift of the count in a rank word.
    localparam int WORD_W    = 64;
    localparam int SEL_IDX_W = 32;
    localparam int RANK_SHIFT = 24;

    // Low three unit bytes of a fresh rank word, all set.
    localparam logic [WORD_W-1:0] RANK_FILL = 64'h0000_0000_00FF_FFFF;
    localparam logic [7:0]        BYTE_FILL = 8'hFF;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        WK_RANK   = 2'd0,
        WK_SELECT = 2'd1,
        WK_REJECT = 2'd2
    } word_kind_t;

    // Everything that one input item leaves for the output side.
    typedef struct packed {
        logic                 rej;
        logic                 rank_v;
        logic [WORD_W-1:0]    rank_word;
        logic                 sel_v;
        logic [SEL_IDX_W-1:0] sel_idx;
    } rsib_entry_t;

endpackage

`default_nettype wire

// ----- rtl/rank_select_index_builder_top.sv -----
// Top level of the rank/select index builder: front, result queue and back.
// Depends on rsib_pkg, rsib_front, rsib_queue and rsib_back.
//
//   Port group   Direction  Handshake          Contents
//   s_*          in         s_valid/s_ready    kind (append or finish), bit_value
//   m_*          out        m_valid/m_ready    word_kind, word_value, last
//   cfg_*        in         cfg_we only        select_enable
//
// The block takes one item in every cycle while its four-entry result queue
// has room; an item that yields no result word leaves the queue untouched.
// The first result word of an item is written to the queue when the item is
// taken and then to the output register; an item with both a rank and a select
// word yields two words; the back drains one word per cycle unless the output stalls.
// Reset is synchronous and active low; it clears the counters, sets the rank
// word to its empty value and sets select_enable. A stall on the output only
// fills the queue, and the front stops taking items once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module rank_select_index_builder_top #(
    parameter int UNIT_BITS  = rsib_pkg::UNIT_BITS_DEF,
    parameter int COUNT_BITS = rsib_pkg::COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_bit_value,
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    // Result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_word_kind,
    output logic [63:0]      m_word_value,
    output logic             m_last
);

    // Entries travel from the front to the queue, and from its head to the back.
    rsib_pkg::rsib_entry_t push_entry;
    rsib_pkg::rsib_entry_t head_entry;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  head_valid;

    // The front owns all index state and the select_enable register.
    rsib_front #(
        .UNIT_BITS  (UNIT_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_bit_value (s_bit_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    // The queue lets the front run ahead while the output is stalled.
    rsib_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // The back splits each entry into one or two result items.
    rsib_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_kind  (m_word_kind),
        .m_word_value (m_word_value),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

// ----- rtl/rsib_front.sv -----
// Front of the rank/select index builder: accepts items, keeps the bit and zero
// counters, builds the rank word and queues the results. Uses rsib_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsib_front #(
    parameter int UNIT_BITS  = rsib_pkg::UNIT_BITS_DEF,
    parameter int COUNT_BITS = rsib_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic                  s_bit_value,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    input  wire logic                  q_full,
    output logic                       q_push,
    output rsib_pkg::rsib_entry_t      q_entry
);

    localparam int BLOCK_BITS = 4 * UNIT_BITS;
    localparam int BW = $clog2(BLOCK_BITS);
    localparam int UW = $clog2(UNIT_BITS);
    // Block quotient width: COUNT_BITS less floor(log2(BLOCK_BITS)).
    localparam int QW = COUNT_BITS - ($clog2(BLOCK_BITS + 1) - 1);
    localparam int SW = (QW + 1 > 32) ? 32 : QW + 1;
    localparam int CW = QW + 1;
    // The rank threshold is BLOCK_BITS times a 32-bit count of rank words, so it
    // returns to zero after its largest value.
    localparam int TW = BW + 32;
    localparam logic [TW-1:0] THRESH_TOP = TW'(BLOCK_BITS) * TW'(32'hFFFF_FFFF);
    localparam int MW = (COUNT_BITS > TW) ? COUNT_BITS : TW;
    localparam int WW = rsib_pkg::WORD_W;
    localparam int IW = rsib_pkg::SEL_IDX_W;

    logic [COUNT_BITS-1:0] bc_reg, bc_next;
    logic [BW-1:0]         br_reg, br_next;
    logic [QW-1:0]         bq_reg, bq_next;
    logic [UW-1:0]         ur_reg, ur_next;
    logic [1:0]            ui_reg, ui_next;
    logic [COUNT_BITS-1:0] zc_reg, zc_next;
    logic [BW-1:0]         zr_reg, zr_next;
    logic [QW-1:0]         zq_reg, zq_next;
    logic [TW-1:0]         thresh_reg, thresh_next;
    logic [SW-1:0]         swe_reg, swe_next;
    logic                  done_reg, done_next;
    logic                  sel_en_reg, sel_en_next;
    logic [WW-1:0]         rank_word_reg, rank_word_next;

    logic [COUNT_BITS-1:0] ones;
    logic [7:0]            diff;
    logic                  accept;
    logic                  rank_due;
    logic [TW-1:0]         thresh_step;
    logic                  sel_due_append;
    logic [CW-1:0]         fin_q;
    logic                  sel_due_finish;

    assign s_ready        = !q_full;
    assign accept         = s_valid && s_ready;
    assign ones           = bc_reg - zc_reg;
    assign diff           = ones[7:0] - rank_word_reg[31:24];
    assign rank_due       = MW'(bc_reg) > MW'(thresh_reg);
    assign thresh_step    = (thresh_reg == THRESH_TOP) ? '0 : thresh_reg + TW'(BLOCK_BITS);
    assign sel_due_append = (zr_reg == '0) && (CW'(zq_reg) >= CW'(swe_reg));
    // Number of the block holding the last zero, plus one.
    assign fin_q          = (zr_reg == '0) ? CW'(zq_reg) : CW'(zq_reg) + CW'(1);
    assign sel_due_finish = (|zc_reg) && (fin_q >= CW'(swe_reg));

    always_comb begin
        bc_next        = bc_reg;
        br_next        = br_reg;
        bq_next        = bq_reg;
        ur_next        = ur_reg;
        ui_next        = ui_reg;
        zc_next        = zc_reg;
        zr_next        = zr_reg;
        zq_next        = zq_reg;
        thresh_next    = thresh_reg;
        swe_next       = swe_reg;
        done_next      = done_reg;
        sel_en_next    = sel_en_reg;
        rank_word_next = rank_word_reg;
        q_entry        = '0;

        if (cfg_we) begin
            sel_en_next = cfg_wdata;
        end

        if (accept) begin
            if (!s_kind) begin
                if (done_reg) begin
                    q_entry.rej = 1'b1;
                end else begin
                    if (rank_due) begin
                        if (br_reg == '0) begin
                            q_entry.rank_v    = 1'b1;
                            q_entry.rank_word = rank_word_reg;
                            thresh_next       = thresh_step;
                            rank_word_next    = (WW'(ones) << rsib_pkg::RANK_SHIFT)
                                                | rsib_pkg::RANK_FILL;
                        end else if (ur_reg == '0) begin
                            case (ui_reg)
                                2'd1:    rank_word_next[7:0]   = diff;
                                2'd2:    rank_word_next[15:8]  = diff;
                                2'd3:    rank_word_next[23:16] = diff;
                                default: rank_word_next        = rank_word_reg;
                            endcase
                        end
                    end
                    if (sel_en_reg && !s_bit_value && sel_due_append) begin
                        q_entry.sel_v   = 1'b1;
                        q_entry.sel_idx = IW'(bq_reg);
                        swe_next        = swe_reg + SW'(1);
                    end

                    // Advance the bit position; a wrap of the count restarts the block.
                    bc_next = bc_reg + COUNT_BITS'(1);
                    if (&bc_reg) begin
                        br_next = '0;
                        bq_next = '0;
                        ur_next = '0;
                        ui_next = '0;
                    end else begin
                        if (br_reg == BW'(BLOCK_BITS - 1)) begin
                            br_next = '0;
                            bq_next = bq_reg + QW'(1);
                        end else begin
                            br_next = br_reg + BW'(1);
                        end
                        if (ur_reg == UW'(UNIT_BITS - 1)) begin
                            ur_next = '0;
                            ui_next = ui_reg + 2'd1;
                        end else begin
                            ur_next = ur_reg + UW'(1);
                        end
                    end

                    if (!s_bit_value) begin
                        zc_next = zc_reg + COUNT_BITS'(1);
                        if (&zc_reg) begin
                            zr_next = '0;
                            zq_next = '0;
                        end else if (zr_reg == BW'(BLOCK_BITS - 1)) begin
                            zr_next = '0;
                            zq_next = zq_reg + QW'(1);
                        end else begin
                            zr_next = zr_reg + BW'(1);
                        end
                    end
                end
            end else begin
                done_next = 1'b1;
                if (rank_due) begin
                    q_entry.rank_v    = 1'b1;
                    q_entry.rank_word = rank_word_reg;
                    thresh_next       = thresh_step;
                end
                if (sel_en_reg && sel_due_finish) begin
                    q_entry.sel_v   = 1'b1;
                    q_entry.sel_idx = IW'(bq_reg);
                    swe_next        = swe_reg + SW'(1);
                end
            end
        end
    end

    assign q_push = accept && (q_entry.rej || q_entry.rank_v || q_entry.sel_v);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg        <= '0;
            br_reg        <= '0;
            bq_reg        <= '0;
            ur_reg        <= '0;
            ui_reg        <= '0;
            zc_reg        <= '0;
            zr_reg        <= '0;
            zq_reg        <= '0;
            thresh_reg    <= '0;
            swe_reg       <= '0;
            done_reg      <= 1'b0;
            sel_en_reg    <= 1'b1;
            rank_word_reg <= rsib_pkg::RANK_FILL;
        end else begin
            bc_reg        <= bc_next;
            br_reg        <= br_next;
            bq_reg        <= bq_next;
            ur_reg        <= ur_next;
            ui_reg        <= ui_next;
            zc_reg        <= zc_next;
            zr_reg        <= zr_next;
            zq_reg        <= zq_next;
            thresh_reg    <= thresh_next;
            swe_reg       <= swe_next;
            done_reg      <= done_next;
            sel_en_reg    <= sel_en_next;
            rank_word_reg <= rank_word_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsib_queue.sv -----
// Short queue of result entries between the front and the back of the
// rank/select index builder. Uses rsib_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rsib_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire rsib_pkg::rsib_entry_t push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output rsib_pkg::rsib_entry_t      head_entry
);

    localparam int DEPTH = rsib_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    rsib_pkg::rsib_entry_t slots_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign full       = fill_reg == NW'(DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsib_back.sv -----
// Back of the rank/select index builder: turns queued entries into result
// items, rank word before select word, through an output register. Uses rsib_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsib_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  head_valid,
    input  wire rsib_pkg::rsib_entry_t head_entry,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_word_kind,
    output logic [63:0]                m_word_value,
    output logic                       m_last
);

    localparam int WW = rsib_pkg::WORD_W;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [WW-1:0] value_reg, value_next;
    logic          last_reg, last_next;
    // Set while the select word of an entry that also had a rank word is owed.
    logic          second_reg, second_next;
    logic          load;

    assign load = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        second_next  = second_reg;
        pop          = 1'b0;

        if (load) begin
            if (head_valid) begin
                m_valid_next = 1'b1;
                if (second_reg) begin
                    kind_next   = rsib_pkg::WK_SELECT;
                    value_next  = WW'(head_entry.sel_idx);
                    last_next   = 1'b1;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end else if (head_entry.rej) begin
                    kind_next  = rsib_pkg::WK_REJECT;
                    value_next = '0;
                    last_next  = 1'b1;
                    pop        = 1'b1;
                end else if (head_entry.rank_v) begin
                    kind_next   = rsib_pkg::WK_RANK;
                    value_next  = head_entry.rank_word;
                    last_next   = !head_entry.sel_v;
                    second_next = head_entry.sel_v;
                    pop         = !head_entry.sel_v;
                end else begin
                    kind_next  = rsib_pkg::WK_SELECT;
                    value_next = WW'(head_entry.sel_idx);
                    last_next  = 1'b1;
                    pop        = 1'b1;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            second_reg  <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_word_kind  = kind_reg;
    assign m_word_value = value_reg;
    assign m_last       = last_reg;

endmodule

`default_nettype wire
